// File: rtl/sdc_pkg.sv
// Shared types and constants, with the FNV-1a offset basis, for the sequenced point dedup checker.
package sdc_pkg;

    localparam int unsigned HashW = 64;
    localparam int unsigned SeqW  = 16;
    localparam int unsigned ByteW = 8;

    localparam logic [HashW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [2:0] {
        VERDICT_SUCCESS    = 3'd0,
        VERDICT_WRONG_MODE = 3'd1,
        VERDICT_GAP        = 3'd2,
        VERDICT_DIFFERS    = 3'd3,
        VERDICT_REJECT     = 3'd4
    } t_verdict;

    typedef struct packed {
        logic            clear_tracking;
        logic [ByteW-1:0] payload_byte;
        logic            last_byte;
        logic [SeqW-1:0] sequence_req;
        logic            queue_mode_active;
        logic [7:0]      admit_status;
        logic [15:0]     queue_depth;
        logic            underran_flag;
    } t_item;

    typedef struct packed {
        t_verdict        verdict;
        logic [7:0]      reject_code;
        logic [SeqW-1:0] echo_sequence;
        logic [SeqW-1:0] next_expected;
        logic            duplicate_ack;
        logic            forward_point;
        logic [15:0]     reported_depth;
        logic            underran_out;
    } t_result;

endpackage

// File: rtl/sdc_fnv_fold.sv
// FNV-1a fold of one byte into a 64-bit hash; prime 2^40 + 0x1b3 as shifts and adds.
module sdc_fnv_fold (
    input  logic [sdc_pkg::HashW-1:0] i_hash,
    input  logic [sdc_pkg::ByteW-1:0] i_byte,
    output logic [sdc_pkg::HashW-1:0] o_hash
);

    logic [sdc_pkg::HashW-1:0] x;

    always_comb begin
        x      = i_hash ^ {{(sdc_pkg::HashW-sdc_pkg::ByteW){1'b0}}, i_byte};
        o_hash = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    end

endmodule

// File: rtl/sdc_in_reg.sv
// Input register: holds one word until the tracking stage takes it.
module sdc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sdc_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_take,
    output logic           o_valid,
    output sdc_pkg::t_item o_item
);

    logic           r_valid;
    sdc_pkg::t_item r_item;
    logic           accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/sdc_track.sv
// Tracking stage: running hash, accepted sequence and hash, verdict and result register.
module sdc_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sdc_pkg::t_item  i_item,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sdc_pkg::t_result o_result
);

    logic [sdc_pkg::HashW-1:0] r_running_hash, n_running_hash;
    logic                      r_tracking_valid, n_tracking_valid;
    logic [sdc_pkg::SeqW-1:0]  r_accepted_sequence, n_accepted_sequence;
    logic [sdc_pkg::HashW-1:0] r_accepted_hash, n_accepted_hash;
    logic                      r_out_valid;
    sdc_pkg::t_result          r_result, n_result;

    logic [sdc_pkg::HashW-1:0] folded;
    logic [sdc_pkg::SeqW-1:0]  seq_plus;
    logic                      makes_result;
    logic                      out_free;

    sdc_fnv_fold u_fold (
        .i_hash (r_running_hash),
        .i_byte (i_item.payload_byte),
        .o_hash (folded)
    );

    assign makes_result = !i_item.clear_tracking && i_item.last_byte;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_take       = i_valid && (!makes_result || out_free);
    assign seq_plus     = r_accepted_sequence + 1'b1;

    always_comb begin
        n_running_hash      = r_running_hash;
        n_tracking_valid    = r_tracking_valid;
        n_accepted_sequence = r_accepted_sequence;
        n_accepted_hash     = r_accepted_hash;

        n_result.verdict        = sdc_pkg::VERDICT_SUCCESS;
        n_result.reject_code    = '0;
        n_result.echo_sequence  = i_item.sequence_req;
        n_result.next_expected  = r_tracking_valid ? seq_plus : i_item.sequence_req;
        n_result.duplicate_ack  = 1'b0;
        n_result.forward_point  = 1'b0;
        n_result.reported_depth = i_item.queue_depth;
        n_result.underran_out   = i_item.underran_flag;

        if (i_item.clear_tracking) begin
            n_running_hash      = sdc_pkg::FnvBasis;
            n_tracking_valid    = 1'b0;
            n_accepted_sequence = '0;
            n_accepted_hash     = '0;
        end else if (!i_item.last_byte) begin
            n_running_hash = folded;
        end else begin
            n_running_hash = sdc_pkg::FnvBasis;
            priority if (!i_item.queue_mode_active) begin
                n_result.verdict        = sdc_pkg::VERDICT_WRONG_MODE;
                n_result.reported_depth = '0;
            end else if (r_tracking_valid && i_item.sequence_req == r_accepted_sequence) begin
                if (folded == r_accepted_hash) begin
                    n_result.duplicate_ack = 1'b1;
                end else begin
                    n_result.verdict = sdc_pkg::VERDICT_DIFFERS;
                end
            end else if (r_tracking_valid && i_item.sequence_req != seq_plus) begin
                n_result.verdict = sdc_pkg::VERDICT_GAP;
            end else if (i_item.admit_status != '0) begin
                n_result.verdict     = sdc_pkg::VERDICT_REJECT;
                n_result.reject_code = i_item.admit_status;
            end else begin
                n_result.forward_point = 1'b1;
                n_result.next_expected = i_item.sequence_req + 1'b1;
                n_tracking_valid       = 1'b1;
                n_accepted_sequence    = i_item.sequence_req;
                n_accepted_hash        = folded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_hash      <= sdc_pkg::FnvBasis;
            r_tracking_valid    <= 1'b0;
            r_accepted_sequence <= '0;
            r_accepted_hash     <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (o_take) begin
                r_running_hash      <= n_running_hash;
                r_tracking_valid    <= n_tracking_valid;
                r_accepted_sequence <= n_accepted_sequence;
                r_accepted_hash     <= n_accepted_hash;
            end
            if (o_take && makes_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && makes_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// File: rtl/sequenced_point_dedup_checker.sv
// Top level of the sequenced point dedup checker.
// Input channel: one serialised payload byte per word (i_in_valid / o_in_stall),
// with the message's sequence, mode, queue verdict, depth and underrun flag
// alongside; the values on the word marked last decide the verdict.
// A word with clear tracking set forgets the tracked sequence and hash and
// drops any partial message; it gives no result.
// Output channel: one result word per message, on its last byte
// (o_out_valid / i_out_stall).
// A last byte is registered in the input register and then in the result
// register, from which the receiver takes it.
// Throughput: one word per cycle while o_in_stall is low; the hash fold and
// the verdict are combinational between the input and result registers.
// When the receiver stalls, the result holds; one further word can wait in
// the input register, and o_in_stall rises only when that word would need
// the occupied result register.
// Reset (i_rst_n low, synchronous) empties both registers, restarts the hash
// at the offset basis and clears tracking.
module sequenced_point_dedup_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_clear_tracking,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_sequence_req,
    input  logic        i_queue_mode_active,
    input  logic [7:0]  i_admit_status,
    input  logic [15:0] i_queue_depth,
    input  logic        i_underran_flag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_verdict,
    output logic [7:0]  o_reject_code,
    output logic [15:0] o_echo_sequence,
    output logic [15:0] o_next_expected,
    output logic        o_duplicate_ack,
    output logic        o_forward_point,
    output logic [15:0] o_reported_depth,
    output logic        o_underran_out
);

    sdc_pkg::t_item   in_item;
    sdc_pkg::t_item   stage_item;
    sdc_pkg::t_result result;
    logic             stage_valid;
    logic             stage_take;

    always_comb begin
        in_item.clear_tracking    = i_clear_tracking;
        in_item.payload_byte      = i_payload_byte;
        in_item.last_byte         = i_last_byte;
        in_item.sequence_req      = i_sequence_req;
        in_item.queue_mode_active = i_queue_mode_active;
        in_item.admit_status      = i_admit_status;
        in_item.queue_depth       = i_queue_depth;
        in_item.underran_flag     = i_underran_flag;
    end

    sdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    sdc_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (stage_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_verdict        = result.verdict;
    assign o_reject_code    = result.reject_code;
    assign o_echo_sequence  = result.echo_sequence;
    assign o_next_expected  = result.next_expected;
    assign o_duplicate_ack  = result.duplicate_ack;
    assign o_forward_point  = result.forward_point;
    assign o_reported_depth = result.reported_depth;
    assign o_underran_out   = result.underran_out;

endmodule

// File: rtl/sdc_checker.sv
// Port-level assertions for the sequenced point dedup checker, bound to the top level.
module sdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_verdict,
    input logic [7:0]  o_reject_code,
    input logic [15:0] o_echo_sequence,
    input logic [15:0] o_next_expected,
    input logic        o_duplicate_ack,
    input logic        o_forward_point,
    input logic [15:0] o_reported_depth,
    input logic        o_underran_out
);

    logic [15:0] echo_plus;
    assign echo_plus = o_echo_sequence + 16'd1;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict)
            && $stable(o_reject_code) && $stable(o_echo_sequence)
            && $stable(o_next_expected) && $stable(o_duplicate_ack)
            && $stable(o_forward_point) && $stable(o_reported_depth)
            && $stable(o_underran_out))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result word valid straight after reset");

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_forward_point |->
            o_verdict == sdc_pkg::VERDICT_SUCCESS && !o_duplicate_ack
            && o_next_expected == echo_plus && o_reject_code == 8'd0)
        else $error("forwarded point with inconsistent result");

    a_reject_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reject_code != 8'd0 |->
            o_verdict == sdc_pkg::VERDICT_REJECT && !o_forward_point)
        else $error("reject code without queue reject verdict");

    a_duplicate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_duplicate_ack |->
            o_verdict == sdc_pkg::VERDICT_SUCCESS && o_next_expected == echo_plus)
        else $error("duplicate acknowledged against untracked sequence");

endmodule

bind sequenced_point_dedup_checker sdc_checker u_sdc_checker (.*);
